// ===== src/dpf_pkg.sv =====
// Shared types and constants for the distinct prime factor core.
// No dependencies; imported by dpf_div and distinct_prime_factors_core.
package dpf_pkg;

    localparam int unsigned NumberW    = 32;
    localparam int unsigned FactorW    = 32;
    localparam int unsigned MaxResults = 9;
    localparam int unsigned CountW     = 4;

    typedef logic [CountW-1:0] count_t;

    localparam count_t LastCount = count_t'(MaxResults - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_TAIL,
        ST_FINAL
    } dpf_state_t;

endpackage

// ===== src/distinct_prime_factors_core.sv =====
// Top level of the distinct prime factor core: trial division control and output stage.
// Depends on dpf_pkg and instantiates dpf_div.
//
//   Channel  Direction  Ports                                Content
//   s_       in         s_valid s_ready s_number             one number per item
//   m_       out        m_valid m_ready m_factor m_found     one prime per item,
//                       m_last                               ascending, last marks end
//
// Each trial divisor launches the bit-serial divider, which produces WIDTH quotient bits,
// and the control then acts on the quotient and remainder. The work for a number grows
// with the number of candidates tried plus repeated divisions by found primes; a prime
// near 2^WIDTH tries about 2^(WIDTH/2) / 2 odd candidates.
// Reset is synchronous and active low and clears all control state; no clearing pass.
// A stalled m_ channel holds the search at its next emitted prime; s_ready is high
// only while no number is in work, and the last result may still sit in the output
// register when the next number is taken.
module distinct_prime_factors_core
    import dpf_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [NumberW-1:0] s_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FactorW-1:0] m_factor,
    output logic               m_found,
    output logic               m_last
);

    dpf_state_t state_reg, state_next;

    // Remaining cofactor and current trial divisor.
    logic [WIDTH-1:0] rest_reg, rest_next;
    logic [WIDTH-1:0] d_reg, d_next;

    // The most recently found prime waits here until we know whether another follows,
    // so that last can be attached to the right item.
    logic [WIDTH-1:0] hold_fac_reg, hold_fac_next;
    logic             hold_found_reg, hold_found_next;
    logic             hold_vld_reg, hold_vld_next;

    count_t           count_reg, count_next;
    logic             infac_reg, infac_next;
    logic             start_reg, start_next;

    logic               m_valid_reg, m_valid_next;
    logic [FactorW-1:0] m_factor_reg, m_factor_next;
    logic               m_found_reg, m_found_next;
    logic               m_last_reg, m_last_next;

    logic             div_done;
    logic [WIDTH-1:0] div_quo;
    logic [WIDTH-1:0] div_rem;

    logic [WIDTH-1:0] num_in;
    logic             num_small;
    logic             past_root;
    logic             rem_zero;
    logic [WIDTH-1:0] d_step;
    logic             out_free;
    logic             push_ok;
    logic             rest_big;

    dpf_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (rest_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign num_in    = WIDTH'(s_number);
    assign num_small = num_in < WIDTH'(2);
    // The search stops once the divisor exceeds rest / divisor.
    assign past_root = d_reg > div_quo;
    assign rem_zero  = div_rem == '0;
    // Candidates are 2 and then the odd numbers from 3 upward.
    assign d_step    = d_reg + ((d_reg == WIDTH'(2)) ? WIDTH'(1) : WIDTH'(2));
    assign out_free  = ~m_valid_reg | m_ready;
    assign push_ok   = ~hold_vld_reg | out_free;
    assign rest_big  = rest_reg > WIDTH'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = num_small ? ST_FINAL : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done && !infac_reg) begin
                    if (past_root) begin
                        state_next = ST_TAIL;
                    end else if (rem_zero) begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                if (push_ok) begin
                    state_next = (count_reg == LastCount) ? ST_FINAL : ST_DIV;
                end
            end
            ST_TAIL: begin
                if (!rest_big || push_ok) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        rest_next       = rest_reg;
        d_next          = d_reg;
        hold_fac_next   = hold_fac_reg;
        hold_found_next = hold_found_reg;
        hold_vld_next   = hold_vld_reg;
        count_next      = count_reg;
        infac_next      = infac_reg;
        start_next      = 1'b0;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_factor_next   = m_factor_reg;
        m_found_next    = m_found_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rest_next  = num_in;
                    d_next     = WIDTH'(2);
                    count_next = '0;
                    infac_next = 1'b0;
                    if (num_small) begin
                        // Zero and one give a single item with no prime.
                        hold_fac_next   = '0;
                        hold_found_next = 1'b0;
                        hold_vld_next   = 1'b1;
                    end else begin
                        hold_vld_next = 1'b0;
                        start_next    = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (infac_reg) begin
                        // Keep dividing out the prime just found.
                        if (rem_zero) begin
                            rest_next  = div_quo;
                        end else begin
                            d_next     = d_step;
                            infac_next = 1'b0;
                        end
                        start_next = 1'b1;
                    end else if (!past_root) begin
                        if (rem_zero) begin
                            rest_next = div_quo;
                        end else begin
                            d_next     = d_step;
                            start_next = 1'b1;
                        end
                    end
                end
            end
            ST_PUSH: begin
                if (push_ok) begin
                    if (hold_vld_reg) begin
                        m_valid_next  = 1'b1;
                        m_factor_next = FactorW'(hold_fac_reg);
                        m_found_next  = hold_found_reg;
                        m_last_next   = 1'b0;
                    end
                    hold_fac_next   = d_reg;
                    hold_found_next = 1'b1;
                    hold_vld_next   = 1'b1;
                    count_next      = count_reg + count_t'(1);
                    if (count_reg != LastCount) begin
                        infac_next = 1'b1;
                        start_next = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                // What remains above one after the search is itself prime.
                if (rest_big && push_ok) begin
                    if (hold_vld_reg) begin
                        m_valid_next  = 1'b1;
                        m_factor_next = FactorW'(hold_fac_reg);
                        m_found_next  = hold_found_reg;
                        m_last_next   = 1'b0;
                    end
                    hold_fac_next   = rest_reg;
                    hold_found_next = 1'b1;
                    hold_vld_next   = 1'b1;
                    count_next      = count_reg + count_t'(1);
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_factor_next = FactorW'(hold_fac_reg);
                    m_found_next  = hold_found_reg;
                    m_last_next   = 1'b1;
                    hold_vld_next = 1'b0;
                end
            end
            default: begin
                hold_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            hold_vld_reg <= 1'b0;
            count_reg    <= '0;
            infac_reg    <= 1'b0;
            start_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hold_vld_reg <= hold_vld_next;
            count_reg    <= count_next;
            infac_reg    <= infac_next;
            start_reg    <= start_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rest_reg       <= rest_next;
        d_reg          <= d_next;
        hold_fac_reg   <= hold_fac_next;
        hold_found_reg <= hold_found_next;
        m_factor_reg   <= m_factor_next;
        m_found_reg    <= m_found_next;
        m_last_reg     <= m_last_next;
    end

    assign s_ready  = state_reg == ST_IDLE;
    assign m_valid  = m_valid_reg;
    assign m_factor = m_factor_reg;
    assign m_found  = m_found_reg;
    assign m_last   = m_last_reg;

    // An item without a prime is always the only, and therefore last, item.
    a_nofound_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_last)
        else $error("item without a prime is not marked last");

    // No pending prime may be left over when a new number is taken.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hold_vld_reg)
        else $error("pending prime left over in idle");

    // The number of primes found never exceeds the result limit.
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= count_t'(MaxResults))
        else $error("prime count beyond limit");

    // The divider finishes only while the control waits on it.
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the division state");

endmodule

// ===== src/dpf_div.sv =====
// Bit-serial restoring divider, one quotient bit per clock.
// Imports dpf_pkg but uses none of its contents; used by distinct_prime_factors_core.
module dpf_div
    import dpf_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int unsigned CntW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CntW-1:0]  cnt_reg;
    logic [WIDTH-1:0] part_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [WIDTH:0]   trial;
    logic             take;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {part_reg, quo_reg[WIDTH-1]} - {1'b0, dvs_reg};
    assign take  = ~trial[WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(WIDTH - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CntW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            part_reg <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            part_reg <= take ? trial[WIDTH-1:0] : {part_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
            quo_reg  <= {quo_reg[WIDTH-2:0], take};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg;

endmodule
